// ----- src/assert_macros.svh -----
// Assertion macros used by multi_resource_fit_check_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ----- src/mrfc_pkg.sv -----
// Constants shared by the multi-resource fit check.
`default_nettype none

package mrfc_pkg;

    localparam int AMOUNT_BITS_DEF = 31;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int REM_BITS    = 48;
    localparam int FITS_BITS   = 16;
    localparam int STATUS_BITS = 3;
    localparam int MODE_BITS   = 2;

    // item kinds, carried in s_tuser
    localparam logic [MODE_BITS-1:0] MODE_LOAD     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_OCCUPANT = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY    = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STATUS = 1'd1;

    // result packing: fits, can_send, three remaining amounts
    localparam int OUT_RAW_BITS = FITS_BITS + 1 + 3 * REM_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS = OUT_BITS - OUT_RAW_BITS;

endpackage

`default_nettype wire

// ----- src/multi_resource_fit_check_core.sv -----
// Multi-resource fit check: sequencer around one shared add/subtract unit.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------------
//  s_ (item) | in        | tuser: mode; tdata: amounts, count, status, linked
//  m_ (res)  | out       | tdata: fits_count, can_send, remaining x3
//  cfg       | in        | cfg_we, cfg_addr, cfg_wdata (write only)
//
// A load only stores the amounts; a negative remaining amount on a query, a filtered-out
// occupant or an unused mode also goes straight to the output stage. Multiply is shift-add
// over the count, divide is restoring, one bit per cycle and one dimension at a time
// through the shared unit.
// s_tready is high only when idle; a result still held in m_tdata stalls only the
// hand-over of the next one. Reset (aresetn low, synchronous) clears amounts and config.
`default_nettype none
`include "assert_macros.svh"

module multi_resource_fit_check_core #(
    parameter int AMOUNT_BITS = mrfc_pkg::AMOUNT_BITS_DEF,
    parameter int COUNT_BITS  = mrfc_pkg::COUNT_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // mode
    input  wire logic [mrfc_pkg::MODE_BITS-1:0] s_tuser,
    // disc_amount, mem_amount, proc_amount, item_count, task_status, linked, zero pad
    input  wire logic [((3*AMOUNT_BITS+COUNT_BITS+mrfc_pkg::STATUS_BITS+1+7)/8)*8-1:0] s_tdata,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // fits_count, can_send, remaining_disc, remaining_mem, remaining_proc, zero pad
    output logic [mrfc_pkg::OUT_BITS-1:0] m_tdata,

    input  wire logic                             cfg_we,
    input  wire logic [mrfc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [mrfc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import mrfc_pkg::*;

    localparam int A  = AMOUNT_BITS;
    localparam int C  = COUNT_BITS;
    localparam int RB = REM_BITS;
    localparam int PW = RB + 1;                       // product, capped at 2**48
    localparam int DW = A + C;                        // divisor shifted up by C
    localparam int AW = ((DW > RB + 3) ? DW : RB + 3) + 1;
    localparam int SW = $clog2(C + 1);
    localparam int EW = FITS_BITS + C;

    localparam int OFS_MEM  = A;
    localparam int OFS_PROC = 2 * A;
    localparam int OFS_CNT  = 3 * A;
    localparam int OFS_ST   = 3 * A + C;
    localparam int OFS_LK   = 3 * A + C + STATUS_BITS;

    localparam logic [PW-1:0]        PROD_CAP  = {1'b1, {RB{1'b0}}};
    localparam logic signed [AW-1:0] REM_MIN_W = {{(AW-RB+1){1'b1}}, {(RB-1){1'b0}}};
    localparam logic [1:0]           DIM_LAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_DIVSET,
        ST_DIV,
        ST_MIN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic                 filter_reg, filter_next;
    logic [STATUS_BITS-1:0] match_reg, match_next;

    logic signed [RB-1:0] rem_reg  [3];
    logic signed [RB-1:0] rem_next [3];
    logic [A-1:0]         need_reg  [3];
    logic [A-1:0]         need_next [3];

    logic [1:0]           dim_reg,  dim_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [PW-1:0]        acc_reg,  acc_next;
    logic [C-1:0]         mcnt_reg, mcnt_next;
    logic [RB-1:0]        rdiv_reg, rdiv_next;
    logic [DW-1:0]        dsr_reg,  dsr_next;
    logic [C:0]           quo_reg,  quo_next;
    logic [C-1:0]         fits_reg, fits_next;
    logic [C-1:0]         cnt_reg,  cnt_next;
    logic                 lk_reg,   lk_next;
    logic [MODE_BITS-1:0] mode_reg, mode_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_BITS-1:0]  m_tdata_reg,  m_tdata_next;

    // shared unit
    logic [AW-1:0] unit_a, unit_b, unit_sum;
    logic          unit_sub;

    logic [EW-1:0] fits_ext;
    logic          send;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            ST_MUL: begin
                unit_a = AW'({acc_reg, 1'b0});
                unit_b = mcnt_reg[C-1] ? AW'(need_reg[dim_reg]) : '0;
            end
            ST_SUB: begin
                unit_a   = {{(AW-RB){rem_reg[dim_reg][RB-1]}}, rem_reg[dim_reg]};
                unit_b   = AW'(acc_reg);
                unit_sub = 1'b1;
            end
            ST_DIV: begin
                unit_a   = AW'(rdiv_reg);
                unit_b   = AW'(dsr_reg);
                unit_sub = 1'b1;
            end
            default: begin
                unit_a = '0;
            end
        endcase
        unit_sum = unit_a + (unit_b ^ {AW{unit_sub}}) + AW'(unit_sub);
    end

    assign fits_ext = {{FITS_BITS{1'b0}}, fits_reg};
    assign send     = (mode_reg == MODE_QUERY) &&
                      (lk_reg ? (fits_reg == cnt_reg) : (fits_reg != '0));

    always_comb begin
        state_next    = state_reg;
        filter_next   = filter_reg;
        match_next    = match_reg;
        dim_next      = dim_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        mcnt_next     = mcnt_reg;
        rdiv_next     = rdiv_reg;
        dsr_next      = dsr_reg;
        quo_next      = quo_reg;
        fits_next     = fits_reg;
        cnt_next      = cnt_reg;
        lk_next       = lk_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        for (int i = 0; i < 3; i++) begin
            rem_next[i]  = rem_reg[i];
            need_next[i] = need_reg[i];
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_addr)
                CFG_FILTER: filter_next = cfg_wdata[0];
                CFG_STATUS: match_next  = cfg_wdata;
                default:    filter_next = filter_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    need_next[0] = s_tdata[A-1:0];
                    need_next[1] = s_tdata[OFS_MEM+A-1:OFS_MEM];
                    need_next[2] = s_tdata[OFS_PROC+A-1:OFS_PROC];
                    cnt_next     = s_tdata[OFS_CNT+C-1:OFS_CNT];
                    lk_next      = s_tdata[OFS_LK];
                    mode_next    = s_tuser;
                    fits_next    = '0;
                    dim_next     = '0;
                    state_next   = ST_OUT;
                    case (s_tuser)
                        MODE_LOAD: begin
                            rem_next[0] = RB'(s_tdata[A-1:0]);
                            rem_next[1] = RB'(s_tdata[OFS_MEM+A-1:OFS_MEM]);
                            rem_next[2] = RB'(s_tdata[OFS_PROC+A-1:OFS_PROC]);
                        end
                        MODE_OCCUPANT: begin
                            if (!filter_reg ||
                                (s_tdata[OFS_ST+STATUS_BITS-1:OFS_ST] == match_reg)) begin
                                acc_next   = '0;
                                mcnt_next  = s_tdata[OFS_CNT+C-1:OFS_CNT];
                                step_next  = SW'(C - 1);
                                state_next = ST_MUL;
                            end
                        end
                        MODE_QUERY: begin
                            // any negative remaining amount leaves fits at zero
                            if (!rem_reg[0][RB-1] && !rem_reg[1][RB-1] && !rem_reg[2][RB-1]) begin
                                fits_next  = s_tdata[OFS_CNT+C-1:OFS_CNT];
                                state_next = ST_DIVSET;
                            end
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_MUL: begin
                // once past the cap the product stays pinned there
                acc_next  = (unit_sum > AW'(PROD_CAP)) ? PROD_CAP : unit_sum[PW-1:0];
                mcnt_next = {mcnt_reg[C-2:0], 1'b0};
                if (step_reg == '0) begin
                    state_next = ST_SUB;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_SUB: begin
                rem_next[dim_reg] = ($signed(unit_sum) < REM_MIN_W) ?
                                    REM_MIN_W[RB-1:0] : unit_sum[RB-1:0];
                if (dim_reg == DIM_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    dim_next   = dim_reg + 1'b1;
                    acc_next   = '0;
                    mcnt_next  = cnt_reg;
                    step_next  = SW'(C - 1);
                    state_next = ST_MUL;
                end
            end

            ST_DIVSET: begin
                rdiv_next  = rem_reg[dim_reg];
                dsr_next   = {need_reg[dim_reg], {C{1'b0}}};
                quo_next   = '0;
                step_next  = SW'(C);
                state_next = ST_DIV;
            end

            ST_DIV: begin
                // top quotient bit flags a quotient of 2**C or more; a zero need ends there too
                if (!unit_sum[AW-1]) begin
                    rdiv_next = unit_sum[RB-1:0];
                end
                quo_next = {quo_reg[C-1:0], !unit_sum[AW-1]};
                dsr_next = dsr_reg >> 1;
                if (step_reg == '0) begin
                    state_next = ST_MIN;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_MIN: begin
                if (!quo_reg[C] && (quo_reg[C-1:0] < fits_reg)) begin
                    fits_next = quo_reg[C-1:0];
                end
                if (dim_reg == DIM_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    dim_next   = dim_reg + 1'b1;
                    state_next = ST_DIVSET;
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_BITS{1'b0}}, rem_reg[2], rem_reg[1], rem_reg[0],
                                     send, fits_ext[FITS_BITS-1:0]};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            filter_reg   <= 1'b0;
            match_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                rem_reg[i]  <= '0;
                need_reg[i] <= '0;
            end
            dim_reg      <= '0;
            step_reg     <= '0;
            acc_reg      <= '0;
            mcnt_reg     <= '0;
            rdiv_reg     <= '0;
            dsr_reg      <= '0;
            quo_reg      <= '0;
            fits_reg     <= '0;
            cnt_reg      <= '0;
            lk_reg       <= 1'b0;
            mode_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            filter_reg   <= filter_next;
            match_reg    <= match_next;
            for (int i = 0; i < 3; i++) begin
                rem_reg[i]  <= rem_next[i];
                need_reg[i] <= need_next[i];
            end
            dim_reg      <= dim_next;
            step_reg     <= step_next;
            acc_reg      <= acc_next;
            mcnt_reg     <= mcnt_next;
            rdiv_reg     <= rdiv_next;
            dsr_reg      <= dsr_next;
            quo_reg      <= quo_next;
            fits_reg     <= fits_next;
            cnt_reg      <= cnt_next;
            lk_reg       <= lk_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn,
                (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `ASSERT_NEVER(a_fits_over_count, aclk, aresetn, fits_reg > cnt_reg, "fits above count")
    `ASSERT_NEVER(a_prod_over_cap, aclk, aresetn, acc_reg > PROD_CAP, "product above cap")
    `ASSERT_NEVER(a_step_range, aclk, aresetn, step_reg > SW'(C), "step out of range")

endmodule

`default_nettype wire

// ----- verif/multi_resource_fit_check_core_test.sv -----
// Self-checking testbench for multi_resource_fit_check_core: load/occupant/query stream.
module multi_resource_fit_check_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfc_pkg::*;

    localparam int AMT = AMOUNT_BITS_DEF;
    localparam int CNT = COUNT_BITS_DEF;
    localparam int IN_BITS = ((3 * AMT + CNT + STATUS_BITS + 1 + 7) / 8) * 8;
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
    localparam logic [AMT-1:0] AMAX = '1;
    localparam logic [CNT-1:0] CMAX = '1;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_ITEMS = 110;
    // per random segment: filter enable and status code to match
    localparam logic [SEGMENTS-1:0] FILTER_PLAN = 8'b1011_0110;
    localparam logic [3*SEGMENTS-1:0] MATCH_PLAN =
        {3'd1, 3'd0, 3'd7, 3'd3, 3'd5, 3'd0, 3'd7, 3'd0};

    typedef logic signed [REM_BITS-1:0] rem_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic [AMT-1:0]         disc;
        logic [AMT-1:0]         mem;
        logic [AMT-1:0]         proc;
        logic [CNT-1:0]         count;
        logic [STATUS_BITS-1:0] status;
        logic                   linked;
    } task_item_t;

    typedef struct packed {
        logic [FITS_BITS-1:0] fits;
        logic                 send;
        rem_t                 disc;
        rem_t                 mem;
        rem_t                 proc;
    } fit_report_t;

    class fit_scoreboard;
        fit_report_t            awaited[$];
        int                     errors;
        logic                   filter_on;
        logic [STATUS_BITS-1:0] match_code;
        rem_t                   disc_left;
        rem_t                   mem_left;
        rem_t                   proc_left;

        function new();
            errors = 0;
            filter_on = 1'b0;
            match_code = '0;
            disc_left = '0;
            mem_left = '0;
            proc_left = '0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == CFG_FILTER)
                filter_on = val[0];
            else if (idx == CFG_STATUS)
                match_code = val[STATUS_BITS-1:0];
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // remaining minus need * copies, clipped at the bottom of the 48-bit range
        function rem_t take_away(rem_t left, logic [AMT-1:0] need, logic [CNT-1:0] copies);
            longint unsigned prod;
            longint diff;
            prod = 64'(need) * 64'(copies);
            if (prod > (64'd1 << REM_BITS))
                prod = 64'd1 << REM_BITS;
            diff = longint'(left) - longint'(prod);
            if (diff < -(longint'(1) << (REM_BITS - 1)))
                diff = -(longint'(1) << (REM_BITS - 1));
            return rem_t'(diff);
        endfunction

        function longint unsigned narrow(longint unsigned bound, rem_t left,
                                         logic [AMT-1:0] need);
            longint unsigned q;
            if (need == '0)
                return bound;
            q = 64'($unsigned(left)) / 64'(need);
            return (q < bound) ? q : bound;
        endfunction

        function void note_item(task_item_t it);
            fit_report_t want;
            longint unsigned fits;
            want = '0;
            fits = 0;
            case (it.mode)
                MODE_LOAD: begin
                    disc_left = rem_t'(it.disc);
                    mem_left = rem_t'(it.mem);
                    proc_left = rem_t'(it.proc);
                end
                MODE_OCCUPANT: begin
                    if (!(filter_on && it.status != match_code)) begin
                        disc_left = take_away(disc_left, it.disc, it.count);
                        mem_left = take_away(mem_left, it.mem, it.count);
                        proc_left = take_away(proc_left, it.proc, it.count);
                    end
                end
                MODE_QUERY: begin
                    if (!disc_left[REM_BITS-1] && !mem_left[REM_BITS-1] &&
                        !proc_left[REM_BITS-1]) begin
                        fits = 64'(it.count);
                        fits = narrow(fits, disc_left, it.disc);
                        fits = narrow(fits, mem_left, it.mem);
                        fits = narrow(fits, proc_left, it.proc);
                    end
                    want.send = it.linked ? (fits >= 64'(it.count)) : (fits != 0);
                end
                default: ;
            endcase
            want.fits = fits[FITS_BITS-1:0];
            want.disc = disc_left;
            want.mem = mem_left;
            want.proc = proc_left;
            awaited.push_back(want);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t ns  %s: expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [OUT_BITS-1:0] word);
            fit_report_t want;
            fit_report_t got;
            got.fits = word[FITS_BITS-1:0];
            got.send = word[FITS_BITS];
            got.disc = word[FITS_BITS + 1 +: REM_BITS];
            got.mem = word[FITS_BITS + 1 + REM_BITS +: REM_BITS];
            got.proc = word[FITS_BITS + 1 + 2 * REM_BITS +: REM_BITS];
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t ns  unexpected result: expected none, got %h", $time, word);
                return;
            end
            want = awaited.pop_front();
            compare("fits_count", want.fits, got.fits);
            compare("can_send", want.send, got.send);
            compare("remaining_disc", want.disc, got.disc);
            compare("remaining_mem", want.mem, got.mem);
            compare("remaining_proc", want.proc, got.proc);
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [MODE_BITS-1:0] s_tuser;
    logic [IN_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_BITS-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    fit_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_request;
    logic [STATUS_BITS-1:0] cur_match;
    int quiet_cycles;

    multi_resource_fit_check_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic task_item_t make_item(logic [MODE_BITS-1:0] mode, logic [AMT-1:0] d,
                                             logic [AMT-1:0] m, logic [AMT-1:0] p,
                                             logic [CNT-1:0] c, logic [STATUS_BITS-1:0] st,
                                             logic lk);
        task_item_t it;
        it.mode = mode;
        it.disc = d;
        it.mem = m;
        it.proc = p;
        it.count = c;
        it.status = st;
        it.linked = lk;
        return it;
    endfunction

    function automatic logic [AMT-1:0] pick_capacity();
        case ($urandom_range(7))
            0: return '0;
            1: return AMAX;
            2, 3, 4: return AMT'($urandom_range(100000));
            default: return AMT'($urandom());
        endcase
    endfunction

    function automatic logic [AMT-1:0] pick_need();
        case ($urandom_range(9))
            0: return '0;
            1: return AMAX;
            2, 3, 4, 5, 6: return AMT'($urandom_range(1000, 1));
            7, 8: return AMT'($urandom_range(1 << 20));
            default: return AMT'($urandom());
        endcase
    endfunction

    function automatic logic [CNT-1:0] pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return CMAX;
            2, 3, 4, 5, 6: return CNT'($urandom_range(64, 1));
            default: return CNT'($urandom());
        endcase
    endfunction

    function automatic task_item_t random_item();
        task_item_t it;
        int roll;
        // fields the mode ignores still get random bits
        it = make_item(MODE_SPARE, AMT'($urandom()), AMT'($urandom()), AMT'($urandom()),
                       CNT'($urandom()), STATUS_BITS'($urandom()), 1'($urandom()));
        roll = $urandom_range(99);
        if (roll < 12) begin
            it.mode = MODE_LOAD;
            it.disc = pick_capacity();
            it.mem = pick_capacity();
            it.proc = pick_capacity();
        end else if (roll < 55) begin
            it.mode = MODE_OCCUPANT;
            it.disc = pick_need();
            it.mem = pick_need();
            it.proc = pick_need();
            it.count = ($urandom_range(9) < 8) ? CNT'($urandom_range(3)) : pick_count();
            if ($urandom_range(1))
                it.status = cur_match;
        end else if (roll < 95) begin
            it.mode = MODE_QUERY;
            it.disc = pick_need();
            it.mem = pick_need();
            it.proc = pick_need();
            it.count = pick_count();
        end
        return it;
    endfunction

    task automatic drive_item(task_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= IN_BITS'({it.linked, it.status, it.count, it.proc, it.mem, it.disc});
        do @(posedge aclk); while (!s_tready);
        board.note_item(it);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        board.set_register(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** multi_resource_fit_check_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        task_item_t opening[$];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        hold_request = 1'b0;
        cur_match = '0;
        send_idle_pct = 7;
        recv_idle_pct = 69;
        board = new();

        // zero state: all-zero need saturates, any need gives nothing
        opening.push_back(make_item(MODE_QUERY, 0, 0, 0, 5, 0, 0));
        opening.push_back(make_item(MODE_QUERY, 1, 0, 0, 3, 0, 1));
        opening.push_back(make_item(MODE_QUERY, 0, 0, 0, 0, 0, 1));
        opening.push_back(make_item(MODE_LOAD, AMAX, AMAX, AMAX, CMAX, 7, 1));
        opening.push_back(make_item(MODE_QUERY, 1, 1, 1, CMAX, 7, 1));
        opening.push_back(make_item(MODE_QUERY, AMAX, 0, 0, 0, 0, 0));
        opening.push_back(make_item(MODE_QUERY, AMAX, AMAX, AMAX, 10, 0, 0));
        opening.push_back(make_item(MODE_OCCUPANT, 1000, 0, 7, 3, 5, 0));
        opening.push_back(make_item(MODE_QUERY, 3, 0, 0, CMAX, 0, 0));
        opening.push_back(make_item(MODE_SPARE, AMAX, AMAX, AMAX, CMAX, 7, 1));
        // drive negative, then down to the saturation floor
        opening.push_back(make_item(MODE_OCCUPANT, AMAX, AMAX, AMAX, CMAX, 0, 1));
        opening.push_back(make_item(MODE_QUERY, 0, 0, 0, 7, 0, 0));
        repeat (4) opening.push_back(make_item(MODE_OCCUPANT, AMAX, AMAX, AMAX, CMAX, 7, 0));
        opening.push_back(make_item(MODE_QUERY, 0, 0, 0, 7, 0, 1));
        opening.push_back(make_item(MODE_LOAD, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_item(MODE_QUERY, 0, 0, 0, CMAX, 0, 1));
        opening.push_back(make_item(MODE_LOAD, 100, 200, 300, 0, 0, 0));
        opening.push_back(make_item(MODE_OCCUPANT, 0, 50, 0, 2, 0, 0));
        opening.push_back(make_item(MODE_QUERY, 7, 0, 30, 50, 0, 1));
        opening.push_back(make_item(MODE_QUERY, 7, 0, 30, 50, 0, 0));
        opening.push_back(make_item(MODE_LOAD, AMAX, 0, 1, 0, 0, 0));
        opening.push_back(make_item(MODE_QUERY, 0, 0, 1, 2, 0, 1));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (opening[i])
            drive_item(opening[i]);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_for_idle();
            cur_match = MATCH_PLAN[seg * 3 +: 3];
            write_register(CFG_FILTER, CFG_DATA_BITS'(FILTER_PLAN[seg]));
            write_register(CFG_STATUS, CFG_DATA_BITS'(cur_match));
            if (seg < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 69;
            end else if (seg < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall while the sender keeps offering
            if (seg == 6)
                hold_request = 1'b1;
            repeat (SEGMENT_ITEMS) drive_item(random_item());
        end

        wait_for_idle();
        repeat (100) @(posedge aclk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("** multi_resource_fit_check_core: PASSED **");
        else
            $display("** multi_resource_fit_check_core: FAILED **");
        $finish;
    end

endmodule

// ----- multi_resource_fit_check_core.f -----
+incdir+src
src/mrfc_pkg.sv
src/multi_resource_fit_check_core.sv
verif/multi_resource_fit_check_core_test.sv
